>>> rtl/ble_pkg.sv
// ----------------------------------------------------------------------------
// ble_pkg: shared types and constants of the battery level estimator
// Request/result payloads, divider handshake, status and register codes,
// sequencer states and the fixed volt/percent table.
// ----------------------------------------------------------------------------
package ble_pkg;

	localparam int TIME_W      = 32;
	localparam int RAW_W       = 12;
	localparam int MV_W        = 13;
	localparam int PCT_W       = 7;
	localparam int STAT_W      = 2;
	localparam int PERIOD_W    = 16;
	localparam int SCALE_W     = 24;
	localparam int CFG_DATA_W  = 24;
	localparam int CFG_IDX_W   = 1;
	localparam int SCALE_SHIFT = 22;
	localparam int PROD_W      = RAW_W + SCALE_W;
	localparam int VOLT_W      = 10;
	localparam int TAB_IDX_W   = 5;
	localparam int DIV_NUM_W   = 20;
	localparam int DIV_DEN_W   = 10;
	localparam int DIV_CNT_W   = $clog2(DIV_NUM_W + 1);

	// Divide a 13-bit average by ten: multiply by ceil(2^17 / 10), keep bits 17 and up
	localparam int VOLT_RECIP_W = 14;
	localparam int VOLT_SHIFT   = 17;
	localparam int VOLT_PROD_W  = MV_W + VOLT_RECIP_W;

	localparam logic [MV_W-1:0]         MV_MAX      = MV_W'(8191);
	localparam logic [VOLT_RECIP_W-1:0] VOLT_RECIP  = VOLT_RECIP_W'(13108);
	localparam logic [PERIOD_W-1:0]     PERIOD_RST  = PERIOD_W'(1000);
	localparam logic [SCALE_W-1:0]      SCALE_RST   = SCALE_W'(6758399);

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOT_READY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE     = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 1'd1;

	typedef struct packed {
		logic [TIME_W-1:0] now_ms;
		logic [RAW_W-1:0]  adc_raw;
	} req_t;

	typedef struct packed {
		logic [MV_W-1:0]   millivolts;
		logic [PCT_W-1:0]  percent;
		logic [STAT_W-1:0] status;
		logic              sampled;
	} res_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quo;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CONV,
		ST_UPD,
		ST_AVG,
		ST_SCL,
		ST_SCAN,
		ST_INTERP,
		ST_PCT_GO,
		ST_PCT_WAIT,
		ST_DONE
	} state_t;

	function automatic logic [VOLT_W-1:0] volt_at(input logic [TAB_IDX_W-1:0] idx);
		logic [VOLT_W-1:0] v;
		case (idx)
			5'd0:  v = 10'd999;
			5'd1:  v = 10'd420;
			5'd2:  v = 10'd415;
			5'd3:  v = 10'd411;
			5'd4:  v = 10'd408;
			5'd5:  v = 10'd402;
			5'd6:  v = 10'd398;
			5'd7:  v = 10'd395;
			5'd8:  v = 10'd391;
			5'd9:  v = 10'd387;
			5'd10: v = 10'd385;
			5'd11: v = 10'd384;
			5'd12: v = 10'd382;
			5'd13: v = 10'd380;
			5'd14: v = 10'd379;
			5'd15: v = 10'd377;
			5'd16: v = 10'd375;
			5'd17: v = 10'd373;
			5'd18: v = 10'd371;
			5'd19: v = 10'd369;
			5'd20: v = 10'd361;
			5'd21: v = 10'd327;
			5'd22: v = 10'd250;
			default: v = 10'd0;
		endcase
		return v;
	endfunction

	function automatic logic [PCT_W-1:0] pct_at(input logic [TAB_IDX_W-1:0] idx);
		logic [PCT_W-1:0] p;
		case (idx)
			5'd0:  p = 7'd100;
			5'd1:  p = 7'd100;
			5'd2:  p = 7'd95;
			5'd3:  p = 7'd90;
			5'd4:  p = 7'd85;
			5'd5:  p = 7'd80;
			5'd6:  p = 7'd75;
			5'd7:  p = 7'd70;
			5'd8:  p = 7'd65;
			5'd9:  p = 7'd60;
			5'd10: p = 7'd55;
			5'd11: p = 7'd50;
			5'd12: p = 7'd45;
			5'd13: p = 7'd40;
			5'd14: p = 7'd35;
			5'd15: p = 7'd30;
			5'd16: p = 7'd25;
			5'd17: p = 7'd20;
			5'd18: p = 7'd15;
			5'd19: p = 7'd10;
			5'd20: p = 7'd5;
			default: p = 7'd0;
		endcase
		return p;
	endfunction

endpackage

>>> rtl/ble_ram.sv
// ----------------------------------------------------------------------------
// ble_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ble_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 20
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/ble_div.sv
// ----------------------------------------------------------------------------
// ble_div: iterative restoring divider
// One quotient bit per cycle; done pulses once the quotient is final.
// ----------------------------------------------------------------------------
module ble_div (
	input  logic                clk,
	input  logic                arst_n,
	input  ble_pkg::div_req_t   req,
	output ble_pkg::div_rsp_t   rsp
);

	logic [ble_pkg::DIV_NUM_W-1:0] quo_q;
	logic [ble_pkg::DIV_DEN_W-1:0] rem_q;
	logic [ble_pkg::DIV_DEN_W-1:0] den_q;
	logic [ble_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [ble_pkg::DIV_DEN_W:0]   shifted;
	logic [ble_pkg::DIV_DEN_W:0]   diff;
	logic                          ge;

	always_comb begin
		shifted = {rem_q, quo_q[ble_pkg::DIV_NUM_W-1]};
		ge      = shifted >= {1'b0, den_q};
		diff    = shifted - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ble_pkg::DIV_CNT_W'(ble_pkg::DIV_NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ble_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[ble_pkg::DIV_DEN_W-1:0] : shifted[ble_pkg::DIV_DEN_W-1:0];
			quo_q <= {quo_q[ble_pkg::DIV_NUM_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

>>> rtl/battery_level_estimator.sv
// ----------------------------------------------------------------------------
// battery_level_estimator: moving-average battery voltage and charge level
// Path: a request with no sample due goes straight to DONE; before the history
// is full a sample passes CONV and UPD; once it fills, also AVG, SCL, a table
// scan of up to 23 steps and, inside an interval, one divider pass. One request
// in flight; reset clears control state, the ring needs no clearing.
// ----------------------------------------------------------------------------
module battery_level_estimator #(
	parameter int HISTORY_DEPTH = 20,
	parameter int TABLE_ENTRIES = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  ble_pkg::req_t                   req_data,
	output logic                            res_valid,
	input  logic                            res_ready,
	output ble_pkg::res_t                   res_data,
	input  logic                            cfg_we,
	input  logic [ble_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [ble_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int IDX_W = $clog2(HISTORY_DEPTH);
	localparam int SUM_W = ble_pkg::MV_W + $clog2(HISTORY_DEPTH);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HISTORY_DEPTH - 1);
	localparam logic [ble_pkg::TAB_IDX_W-1:0] SCAN_LAST =
		ble_pkg::TAB_IDX_W'(TABLE_ENTRIES - 1);
	localparam int MVR_W = ble_pkg::PROD_W - ble_pkg::SCALE_SHIFT;
	// Sum by depth as a multiply by a rounded-up reciprocal, exact for any sum
	localparam int AVG_SHIFT  = SUM_W + $clog2(HISTORY_DEPTH);
	localparam int RECIP_W    = SUM_W + 1;
	localparam int AVG_PROD_W = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] AVG_RECIP = RECIP_W'(((longint'(1) << AVG_SHIFT)
		+ longint'(HISTORY_DEPTH) - 1) / longint'(HISTORY_DEPTH));

	// Sequencer and configuration
	ble_pkg::state_t                 state_q, state_d;
	logic [ble_pkg::PERIOD_W-1:0]    period_q;
	logic [ble_pkg::SCALE_W-1:0]     scale_q;

	// Per-request context
	logic [ble_pkg::TIME_W-1:0]      last_q;
	logic [ble_pkg::RAW_W-1:0]       raw_q;
	logic                            sampled_q;
	logic [ble_pkg::PROD_W-1:0]      prod_s1;

	// History bookkeeping; entries themselves live in the RAM
	logic [IDX_W-1:0]                idx_q;
	logic                            full_q;
	logic [SUM_W-1:0]                sum_q;
	logic [ble_pkg::MV_W-1:0]        avg_q;

	// Table scan and interpolation
	logic [ble_pkg::VOLT_W-1:0]      v_q;
	logic [ble_pkg::TAB_IDX_W-1:0]   scan_q;
	logic [ble_pkg::VOLT_W-1:0]      hi_q, lo_q;
	logic [ble_pkg::PCT_W-1:0]       p0_q, p1_q;
	logic [ble_pkg::DIV_NUM_W-1:0]   num_q;
	logic [ble_pkg::DIV_DEN_W-1:0]   den_q;

	// Cached level for the current average
	logic [ble_pkg::PCT_W-1:0]       pct_q;
	logic [ble_pkg::STAT_W-1:0]      stat_q;

	// Result register
	logic                            res_valid_q;
	ble_pkg::res_t                   res_q;

	// Combinational helpers
	logic                            take;
	logic [ble_pkg::TIME_W-1:0]      elapsed;
	logic                            due;
	logic [MVR_W-1:0]                mv_raw;
	logic [ble_pkg::MV_W-1:0]        mv_new;
	logic [ble_pkg::MV_W-1:0]        mv_old;
	logic                            idx_wrap;
	logic [AVG_PROD_W-1:0]           avg_prod;
	logic [ble_pkg::VOLT_PROD_W-1:0] volt_prod;
	logic [ble_pkg::VOLT_W-1:0]      tab_hi, tab_lo;
	logic                            hit_eq, hit_in;
	logic                            res_load;
	logic                            ram_re, ram_we;
	logic [ble_pkg::MV_W-1:0]        ram_rdata;
	ble_pkg::div_req_t               div_req;
	ble_pkg::div_rsp_t               div_rsp;

	// History ring: read old entry in CONV, write the new one in UPD. The read
	// and write of one entry never overlap because one request runs at a time.
	ble_ram #(
		.WIDTH (ble_pkg::MV_W),
		.DEPTH (HISTORY_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (mv_new),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	// Divider for the interpolation over the bracketing interval
	ble_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		take     = req_valid && req_ready;
		elapsed  = req_data.now_ms - last_q;
		due      = elapsed >= ble_pkg::TIME_W'(period_q);
		// Convert: keep the integer millivolts, saturate to the field range
		mv_raw   = prod_s1[ble_pkg::PROD_W-1:ble_pkg::SCALE_SHIFT];
		mv_new   = (mv_raw > MVR_W'(ble_pkg::MV_MAX)) ? ble_pkg::MV_MAX
		                                               : mv_raw[ble_pkg::MV_W-1:0];
		// Entries not yet written count as zero until the first wrap
		mv_old   = full_q ? ram_rdata : '0;
		idx_wrap = idx_q == IDX_LAST;
		avg_prod  = AVG_PROD_W'(sum_q) * AVG_PROD_W'(AVG_RECIP);
		volt_prod = ble_pkg::VOLT_PROD_W'(avg_q) * ble_pkg::VOLT_PROD_W'(ble_pkg::VOLT_RECIP);
		tab_hi   = ble_pkg::volt_at(scan_q - 1'b1);
		tab_lo   = ble_pkg::volt_at(scan_q);
		hit_eq   = v_q == tab_lo;
		hit_in   = (v_q < tab_hi) && (v_q > tab_lo);
		res_load = (state_q == ble_pkg::ST_DONE) && (!res_valid_q || res_ready);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ble_pkg::ST_IDLE: begin
				if (take) begin
					state_d = due ? ble_pkg::ST_CONV : ble_pkg::ST_DONE;
				end
			end
			ble_pkg::ST_CONV: state_d = ble_pkg::ST_UPD;
			ble_pkg::ST_UPD: begin
				state_d = (full_q || idx_wrap) ? ble_pkg::ST_AVG : ble_pkg::ST_DONE;
			end
			ble_pkg::ST_AVG: state_d = ble_pkg::ST_SCL;
			ble_pkg::ST_SCL: state_d = ble_pkg::ST_SCAN;
			ble_pkg::ST_SCAN: begin
				if (hit_eq || scan_q == SCAN_LAST) begin
					state_d = ble_pkg::ST_DONE;
				end else if (hit_in) begin
					state_d = ble_pkg::ST_INTERP;
				end
				// the "hit inside" check wins over the last-entry check
				if (!hit_eq && hit_in) begin
					state_d = ble_pkg::ST_INTERP;
				end
			end
			ble_pkg::ST_INTERP: state_d = ble_pkg::ST_PCT_GO;
			ble_pkg::ST_PCT_GO: state_d = ble_pkg::ST_PCT_WAIT;
			ble_pkg::ST_PCT_WAIT: begin
				if (div_rsp.done) begin
					state_d = ble_pkg::ST_DONE;
				end
			end
			ble_pkg::ST_DONE: begin
				if (res_load) begin
					state_d = ble_pkg::ST_IDLE;
				end
			end
			default: state_d = ble_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		req_ready     = 1'b0;
		ram_re        = 1'b0;
		ram_we        = 1'b0;
		div_req.start = 1'b0;
		div_req.num   = '0;
		div_req.den   = '0;
		case (state_q)
			ble_pkg::ST_IDLE: req_ready = 1'b1;
			ble_pkg::ST_CONV: ram_re = 1'b1;
			ble_pkg::ST_UPD:  ram_we = 1'b1;
			ble_pkg::ST_PCT_GO: begin
				div_req.start = 1'b1;
				div_req.num   = num_q;
				div_req.den   = den_q;
			end
			default: begin
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ble_pkg::ST_IDLE;
			period_q    <= ble_pkg::PERIOD_RST;
			scale_q     <= ble_pkg::SCALE_RST;
			last_q      <= '0;
			idx_q       <= '0;
			full_q      <= 1'b0;
			sum_q       <= '0;
			avg_q       <= '0;
			pct_q       <= '0;
			stat_q      <= ble_pkg::STAT_NOT_READY;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				case (cfg_idx)
					ble_pkg::CFG_PERIOD: period_q <= cfg_wdata[ble_pkg::PERIOD_W-1:0];
					ble_pkg::CFG_SCALE:  scale_q  <= cfg_wdata[ble_pkg::SCALE_W-1:0];
					default: begin
					end
				endcase
			end

			// Stamp the time of every accepted sample
			if (take && due) begin
				last_q <= req_data.now_ms;
			end

			// Advance the ring and keep a running sum: add new, drop old
			if (state_q == ble_pkg::ST_UPD) begin
				sum_q <= sum_q - SUM_W'(mv_old) + SUM_W'(mv_new);
				idx_q <= idx_wrap ? '0 : idx_q + 1'b1;
				if (idx_wrap) begin
					full_q <= 1'b1;
				end
			end

			if (state_q == ble_pkg::ST_AVG) begin
				avg_q <= avg_prod[AVG_SHIFT +: ble_pkg::MV_W];
			end

			// Refresh the cached level each time the average is recomputed
			if (state_q == ble_pkg::ST_SCAN && state_d == ble_pkg::ST_DONE) begin
				if (hit_eq) begin
					pct_q  <= ble_pkg::pct_at(scan_q);
					stat_q <= ble_pkg::STAT_OK;
				end else begin
					pct_q  <= '0;
					stat_q <= ble_pkg::STAT_RANGE;
				end
			end
			if (state_q == ble_pkg::ST_PCT_WAIT && div_rsp.done) begin
				pct_q  <= div_rsp.quo[ble_pkg::PCT_W-1:0];
				stat_q <= ble_pkg::STAT_OK;
			end

			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (take) begin
			raw_q     <= req_data.adc_raw;
			sampled_q <= due;
		end
		if (state_q == ble_pkg::ST_CONV) begin
			prod_s1 <= ble_pkg::PROD_W'(raw_q) * ble_pkg::PROD_W'(scale_q);
		end
		// Scale the average to 10 mV units and start the scan at the first interval
		if (state_q == ble_pkg::ST_SCL) begin
			v_q    <= volt_prod[ble_pkg::VOLT_SHIFT +: ble_pkg::VOLT_W];
			scan_q <= ble_pkg::TAB_IDX_W'(1);
		end
		if (state_q == ble_pkg::ST_SCAN) begin
			hi_q   <= tab_hi;
			lo_q   <= tab_lo;
			p0_q   <= ble_pkg::pct_at(scan_q - 1'b1);
			p1_q   <= ble_pkg::pct_at(scan_q);
			scan_q <= scan_q + 1'b1;
		end
		// Weighted sum of the bracketing percentages over the interval width
		if (state_q == ble_pkg::ST_INTERP) begin
			num_q <= ble_pkg::DIV_NUM_W'(p0_q) * ble_pkg::DIV_NUM_W'(v_q - lo_q)
			       + ble_pkg::DIV_NUM_W'(p1_q) * ble_pkg::DIV_NUM_W'(hi_q - v_q);
			den_q <= ble_pkg::DIV_DEN_W'(hi_q - lo_q);
		end
		// Hold zero for level and voltage until the history is full
		if (res_load) begin
			res_q.millivolts <= full_q ? avg_q : '0;
			res_q.percent    <= full_q ? pct_q : '0;
			res_q.status     <= full_q ? stat_q : ble_pkg::STAT_NOT_READY;
			res_q.sampled    <= sampled_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |=> full_q)
		else $error("history full flag dropped");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_LAST)
		else $error("ring index out of range");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ble_pkg::ST_PCT_WAIT)
		else $error("divider finished outside a wait state");

	a_not_ready_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.status != ble_pkg::STAT_OK) |-> res_q.percent == '0)
		else $error("percent set on a result that is not ok");

endmodule
